FILE: rtl/core/heq_pkg.sv
// ----------------------------------------------------------------------------
// heq_pkg - histogram equalizer shared definitions
// Sizes, derived widths and sequencer states used by the equalizer core.
// ----------------------------------------------------------------------------
package heq_pkg;

  localparam int LEVELS     = 256;
  localparam int IDX_W      = $clog2(LEVELS);
  localparam int COUNT_BITS = 22;
  localparam int PIX_W      = 8;
  // (cdf - cdf_min) * (LEVELS - 1) needs the count width plus the index width
  localparam int NUM_W      = COUNT_BITS + IDX_W;
  localparam int QBIT_W     = $clog2(PIX_W);

  localparam logic [COUNT_BITS-1:0] COUNT_CAP = {COUNT_BITS{1'b1}};
  localparam logic [IDX_W-1:0]      IDX_LAST  = IDX_W'(LEVELS - 1);

  localparam logic OP_COUNT = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CNT_UPD,
    ST_B1_RD,
    ST_B1_ACC,
    ST_B1_END,
    ST_PT_WR,
    ST_P2_RD,
    ST_P2_ACC,
    ST_P2_DIV,
    ST_P2_WR,
    ST_MAP_OUT
  } heq_state_t;

endpackage

FILE: rtl/core/histogram_equalizer_core.sv
// ----------------------------------------------------------------------------
// histogram_equalizer_core - two-pass 8-bit histogram equalization
// Count requests fill a histogram; the last count request builds a lookup
// table; map requests return table entries and the last one clears the frame.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  input   | in_valid/in_ready, in_operation,        | in
//          | in_pixel, in_last                       |
//  result  | out_valid/out_ready, out_mapped_pixel,  | out
//          | out_saturated, out_last_out             |
//
//  A map request passes through ST_MAP_OUT, a count request through ST_CNT_UPD.
//  A count request marked last adds a table build: a histogram scan (read and
//  accumulate per bin), ST_B1_END to pick the fill, then a pass-through fill
//  or a divide pass per bin through the 8-step restoring divider.
//  Reset clears the bin valid flags at once; no clearing sweep is needed.
//  A map request waits in ST_MAP_OUT only while the previous result is untaken.
// ----------------------------------------------------------------------------
module histogram_equalizer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [heq_pkg::PIX_W-1:0]  in_pixel,
  input  logic                       in_last,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [heq_pkg::PIX_W-1:0]  out_mapped_pixel,
  output logic                       out_saturated,
  output logic                       out_last_out
);

  localparam int CB = heq_pkg::COUNT_BITS;
  localparam int IW = heq_pkg::IDX_W;
  localparam int NW = heq_pkg::NUM_W;
  localparam int PW = heq_pkg::PIX_W;
  localparam int QW = heq_pkg::QBIT_W;

  // Histogram RAM and table RAM
  logic [CB-1:0] bin_mem [heq_pkg::LEVELS];
  logic [PW-1:0] lm_mem  [heq_pkg::LEVELS];

  heq_pkg::heq_state_t state_r, state_nxt;

  logic [heq_pkg::LEVELS-1:0] bin_valid_r, bin_valid_nxt;
  logic [CB-1:0] total_r, total_nxt;
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] pix_r, pix_nxt;
  logic          last_r, last_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CB-1:0] cum_r, cum_nxt;
  logic [CB-1:0] cdfmin_r, cdfmin_nxt;
  logic [CB-1:0] span_r, span_nxt;
  logic [NW-1:0] rem_r, rem_nxt;
  logic [PW-1:0] q_r, q_nxt;
  logic [QW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_pix_r, out_pix_nxt;
  logic          out_sat_r, out_sat_nxt;
  logic          out_last_r, out_last_nxt;

  // RAM ports
  logic [IW-1:0] bin_rd_addr;
  logic [CB-1:0] bin_q_r;
  logic          bin_vld_r;
  logic          bin_we;
  logic [CB-1:0] bin_wdata;
  logic [IW-1:0] lm_rd_addr;
  logic [PW-1:0] lm_q_r;
  logic          lm_we;
  logic [PW-1:0] lm_wdata;

  logic [CB-1:0] bin_val;
  logic [CB-1:0] cum_sum;
  logic [CB-1:0] diff;
  logic [NW-1:0] div_shift;

  assign bin_val   = bin_vld_r ? bin_q_r : '0;
  assign cum_sum   = cum_r + bin_val;
  assign diff      = cum_sum - cdfmin_r;
  assign div_shift = NW'(span_r) << k_r;

  assign bin_rd_addr = (state_r == heq_pkg::ST_IDLE) ? in_pixel[IW-1:0] : idx_r;
  assign lm_rd_addr  = (state_r == heq_pkg::ST_IDLE) ? in_pixel[IW-1:0] : pix_r;

  always_ff @(posedge clk) begin
    bin_q_r   <= bin_mem[bin_rd_addr];
    bin_vld_r <= bin_valid_r[bin_rd_addr];
    if (bin_we) begin
      bin_mem[pix_r] <= bin_wdata;
    end
  end

  always_ff @(posedge clk) begin
    lm_q_r <= lm_mem[lm_rd_addr];
    if (lm_we) begin
      lm_mem[idx_r] <= lm_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= heq_pkg::ST_IDLE;
      bin_valid_r <= '0;
      total_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bin_valid_r <= bin_valid_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pix_r      <= pix_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    cum_r      <= cum_nxt;
    cdfmin_r   <= cdfmin_nxt;
    span_r     <= span_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    k_r        <= k_nxt;
    out_pix_r  <= out_pix_nxt;
    out_sat_r  <= out_sat_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    bin_valid_nxt = bin_valid_r;
    total_nxt     = total_r;
    ovf_nxt       = ovf_r;
    pix_nxt       = pix_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    cum_nxt       = cum_r;
    cdfmin_nxt    = cdfmin_r;
    span_nxt      = span_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    k_nxt         = k_r;
    out_pix_nxt   = out_pix_r;
    out_sat_nxt   = out_sat_r;
    out_last_nxt  = out_last_r;
    bin_we        = 1'b0;
    bin_wdata     = bin_val + CB'(1);
    lm_we         = 1'b0;
    lm_wdata      = q_r;
    in_ready      = 1'b0;

    // drop the result once the consumer takes it
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      heq_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          pix_nxt  = in_pixel[IW-1:0];
          last_nxt = in_last;
          state_nxt = (in_operation == heq_pkg::OP_MAP) ? heq_pkg::ST_MAP_OUT
                                                        : heq_pkg::ST_CNT_UPD;
        end
      end

      // read-modify-write of one bin; hold the count at capacity
      heq_pkg::ST_CNT_UPD: begin
        if (total_r != heq_pkg::COUNT_CAP) begin
          total_nxt = total_r + CB'(1);
          if (bin_val != heq_pkg::COUNT_CAP) begin
            bin_we               = 1'b1;
            bin_valid_nxt[pix_r] = 1'b1;
          end
        end else begin
          ovf_nxt = 1'b1;
        end
        if (last_r) begin
          idx_nxt    = '0;
          cum_nxt    = '0;
          cdfmin_nxt = '0;
          state_nxt  = heq_pkg::ST_B1_RD;
        end else begin
          state_nxt = heq_pkg::ST_IDLE;
        end
      end

      // first scan: find the smallest nonzero cumulative count
      heq_pkg::ST_B1_RD: begin
        state_nxt = heq_pkg::ST_B1_ACC;
      end

      heq_pkg::ST_B1_ACC: begin
        cum_nxt = cum_sum;
        if (cdfmin_r == '0 && cum_sum != '0) begin
          cdfmin_nxt = cum_sum;
        end
        if (idx_r == heq_pkg::IDX_LAST) begin
          state_nxt = heq_pkg::ST_B1_END;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = heq_pkg::ST_B1_RD;
        end
      end

      heq_pkg::ST_B1_END: begin
        idx_nxt  = '0;
        cum_nxt  = '0;
        span_nxt = total_r - cdfmin_r;
        state_nxt = (total_r <= cdfmin_r) ? heq_pkg::ST_PT_WR : heq_pkg::ST_P2_RD;
      end

      // flat or empty histogram: identity table
      heq_pkg::ST_PT_WR: begin
        lm_we    = 1'b1;
        lm_wdata = PW'(idx_r);
        if (idx_r == heq_pkg::IDX_LAST) begin
          state_nxt = heq_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      heq_pkg::ST_P2_RD: begin
        state_nxt = heq_pkg::ST_P2_ACC;
      end

      // numerator (cdf - cdf_min) * (LEVELS - 1), zero below the first bin
      heq_pkg::ST_P2_ACC: begin
        cum_nxt = cum_sum;
        if (cum_sum >= cdfmin_r) begin
          rem_nxt = (NW'(diff) << IW) - NW'(diff);
        end else begin
          rem_nxt = '0;
        end
        q_nxt     = '0;
        k_nxt     = QW'(PW - 1);
        state_nxt = heq_pkg::ST_P2_DIV;
      end

      // restoring divide, one quotient bit per cycle, MSB first
      heq_pkg::ST_P2_DIV: begin
        if (rem_r >= div_shift) begin
          rem_nxt = rem_r - div_shift;
          q_nxt   = q_r | (PW'(1) << k_r);
        end
        if (k_r == '0) begin
          state_nxt = heq_pkg::ST_P2_WR;
        end else begin
          k_nxt = k_r - QW'(1);
        end
      end

      heq_pkg::ST_P2_WR: begin
        lm_we = 1'b1;
        if (idx_r == heq_pkg::IDX_LAST) begin
          state_nxt = heq_pkg::ST_IDLE;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = heq_pkg::ST_P2_RD;
        end
      end

      // hold until the result register is free, then clear the frame on last
      heq_pkg::ST_MAP_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = lm_q_r;
          out_sat_nxt   = ovf_r;
          out_last_nxt  = last_r;
          if (last_r) begin
            bin_valid_nxt = '0;
            total_nxt     = '0;
            ovf_nxt       = 1'b0;
          end
          state_nxt = heq_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = heq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_mapped_pixel = out_pix_r;
  assign out_saturated    = out_sat_r;
  assign out_last_out     = out_last_r;

endmodule

FILE: tb/histogram_equalizer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// histogram_equalizer_core_tb - self-checking bench for the equalizer core
// Drives count and map frames with bursty input and a stalling receiver,
// predicts every mapped pixel from an internal histogram/table model and
// compares each whole result, all fields at once, in arrival order.
// ----------------------------------------------------------------------------
module histogram_equalizer_core_tb;

  typedef struct packed {
    logic [heq_pkg::PIX_W-1:0] mapped_pixel;
    logic                      saturated;
    logic                      last_out;
  } heq_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_operation;
  logic [heq_pkg::PIX_W-1:0] in_pixel;
  logic                      in_last;
  logic                      out_valid;
  logic                      out_ready;
  logic [heq_pkg::PIX_W-1:0] out_mapped_pixel;
  logic                      out_saturated;
  logic                      out_last_out;

  // Predictor state: histogram, running total, overflow flag and level table
  logic [heq_pkg::COUNT_BITS-1:0] hist_bins [heq_pkg::LEVELS];
  logic [heq_pkg::PIX_W-1:0]      lut       [heq_pkg::LEVELS];
  logic [heq_pkg::COUNT_BITS-1:0] frame_total;
  logic                           frame_ovf;

  heq_result_t pending_maps[$];
  int          mismatch_count;
  longint      cycle_count;
  bit          hold_receiver;
  bit          sender_bursty;

  localparam longint CYCLE_LIMIT = 64'd3_000_000;

  histogram_equalizer_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_pixel         (in_pixel),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_mapped_pixel (out_mapped_pixel),
    .out_saturated    (out_saturated),
    .out_last_out     (out_last_out)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Rebuild the level table from the inclusive cumulative histogram
  function automatic void build_lut();
    longint cum;
    longint cmin;
    longint span;
    longint v;
    cum  = 0;
    cmin = 0;
    for (int i = 0; i < heq_pkg::LEVELS; i++) begin
      cum += hist_bins[i];
      if (cmin == 0 && cum != 0) cmin = cum;
    end
    // Flat or empty histogram: pass every level through unchanged
    if (frame_total <= cmin) begin
      for (int i = 0; i < heq_pkg::LEVELS; i++) lut[i] = heq_pkg::PIX_W'(i);
      return;
    end
    span = frame_total - cmin;
    cum  = 0;
    for (int i = 0; i < heq_pkg::LEVELS; i++) begin
      cum += hist_bins[i];
      v = (cum >= cmin) ? ((cum - cmin) * (heq_pkg::LEVELS - 1)) / span : 0;
      lut[i] = heq_pkg::PIX_W'(v);
    end
  endfunction

  // Queue one expected result behind the ones already waiting
  function automatic void queue_expected(heq_result_t r);
    pending_maps = {pending_maps, r};
  endfunction

  // Advance the predictor by one accepted request
  function automatic void predict_request(logic op, logic [heq_pkg::PIX_W-1:0] px,
                                          logic lst);
    heq_result_t r;
    if (op == heq_pkg::OP_COUNT) begin
      // Drop the count once the total sits at capacity
      if (frame_total == heq_pkg::COUNT_CAP) begin
        frame_ovf = 1'b1;
      end else begin
        frame_total++;
        if (hist_bins[px] != heq_pkg::COUNT_CAP) hist_bins[px]++;
      end
      if (lst) begin
        build_lut();
      end
    end else begin
      r.mapped_pixel = lut[px];
      r.saturated    = frame_ovf;
      r.last_out     = lst;
      queue_expected(r);
      if (lst) begin
        foreach (hist_bins[i]) hist_bins[i] = '0;
        frame_total = '0;
        frame_ovf   = 1'b0;
      end
    end
  endfunction

  // Send one request; hold valid and payload until accepted
  task automatic send_request(logic op, logic [heq_pkg::PIX_W-1:0] px, logic lst);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_pixel     <= px;
    in_last      <= lst;
    do @(posedge clk); while (!in_ready);
    predict_request(op, px, lst);
    // Idle between bursts; keep valid high inside a burst
    if (sender_bursty && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Random pixel, leaning on the extremes now and then
  function automatic logic [heq_pkg::PIX_W-1:0] pick_pixel(int lo, int hi);
    case ($urandom_range(0, 9))
      0:       return heq_pkg::PIX_W'(lo);
      1:       return heq_pkg::PIX_W'(hi);
      default: return heq_pkg::PIX_W'($urandom_range(lo, hi));
    endcase
  endfunction

  task automatic count_pass(int n, int lo, int hi);
    for (int i = 0; i < n; i++)
      send_request(heq_pkg::OP_COUNT, pick_pixel(lo, hi), i == n - 1);
  endtask

  task automatic map_pass(int n);
    for (int i = 0; i < n; i++)
      send_request(heq_pkg::OP_MAP, pick_pixel(0, 255), i == n - 1);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
  endtask

  // Directed: extremes, flat histograms, sparse bins, rebuild after counts
  task automatic test_directed();
    send_request(heq_pkg::OP_COUNT, 8'd0, 1'b1);
    send_request(heq_pkg::OP_MAP, 8'd0, 1'b0);
    send_request(heq_pkg::OP_MAP, 8'd255, 1'b1);
    send_request(heq_pkg::OP_COUNT, 8'd77, 1'b0);
    send_request(heq_pkg::OP_COUNT, 8'd77, 1'b1);
    send_request(heq_pkg::OP_MAP, 8'd76, 1'b0);
    send_request(heq_pkg::OP_MAP, 8'd77, 1'b1);
    send_request(heq_pkg::OP_COUNT, 8'd0, 1'b0);
    send_request(heq_pkg::OP_COUNT, 8'd255, 1'b0);
    send_request(heq_pkg::OP_COUNT, 8'd128, 1'b1);
    send_request(heq_pkg::OP_MAP, 8'd0, 1'b0);
    send_request(heq_pkg::OP_MAP, 8'd128, 1'b0);
    // Keep counting after the build; table stays until the next last count
    send_request(heq_pkg::OP_COUNT, 8'd5, 1'b0);
    send_request(heq_pkg::OP_COUNT, 8'd200, 1'b1);
    send_request(heq_pkg::OP_MAP, 8'd5, 1'b0);
    send_request(heq_pkg::OP_MAP, 8'd100, 1'b0);
    send_request(heq_pkg::OP_MAP, 8'd255, 1'b1);
    wait_drain();
  endtask

  // Random frames, mostly small, a few wide
  task automatic test_random_frames();
    int lo;
    int hi;
    for (int f = 0; f < 7; f++) begin
      lo = $urandom_range(0, 255);
      hi = $urandom_range(lo, 255);
      if (f % 4 == 0) begin
        lo = 0;
        hi = 255;
      end
      count_pass($urandom_range(1, 40), lo, hi);
      map_pass($urandom_range(1, 20));
      // Occasional stray map without last against the current table
      if ($urandom_range(0, 3) == 0)
        send_request(heq_pkg::OP_MAP, pick_pixel(0, 255), 1'b0);
      map_pass(1);
    end
    wait_drain();
  endtask

  // Hold the receiver off while maps keep coming so the core backs up
  task automatic test_backpressure();
    count_pass(10, 0, 255);
    hold_receiver = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_receiver = 1'b0;
      end
      map_pass(30);
    join
    wait_drain();
  endtask

  // Result checker
  always @(posedge clk) begin
    heq_result_t got;
    heq_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_mapped_pixel, out_saturated, out_last_out};
      if (pending_maps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = pending_maps.pop_front();
        if (got !== exp_r) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected %p got %p", exp_r, got);
        end
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (hold_receiver) out_ready <= 1'b0;
    else out_ready <= (cycle_count % 37 < 25) ? ($urandom_range(0, 3) != 0) : 1'b1;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("histogram_equalizer_core verification failed");
      $finish;
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = heq_pkg::OP_COUNT;
    in_pixel       = '0;
    in_last        = 1'b0;
    cycle_count    = 0;
    mismatch_count = 0;
    hold_receiver  = 1'b0;
    sender_bursty  = 1'b0;
    frame_total    = '0;
    frame_ovf      = 1'b0;
    foreach (hist_bins[i]) hist_bins[i] = '0;
    foreach (lut[i]) lut[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    sender_bursty = 1'b1;
    test_random_frames();
    test_backpressure();
    test_random_frames();
    sender_bursty = 1'b0;
    test_random_frames();
    sender_bursty = 1'b1;
    test_random_frames();
    wait_drain();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && pending_maps.size() == 0) begin
      $display("histogram_equalizer_core verification clean");
    end else begin
      $display("histogram_equalizer_core verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/heq_pkg.sv
rtl/core/histogram_equalizer_core.sv
tb/histogram_equalizer_core_tb.sv
